>>> design/assert_macros.svh
// Assertion shorthands for the pose averaging checker.
// Each expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define PWMA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pwma check failed");

// Consequent must hold in the same cycle as the antecedent.
`define PWMA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pwma check failed");

`endif

>>> design/pwma_pkg.sv
`timescale 1ns / 1ps
package pwma_pkg;

	localparam int PWMA_WINDOW_MAX_DFLT = 16;

	localparam int POS_W     = 32;
	localparam int YAW_W     = 16;
	localparam int STAMP_W   = 40;
	localparam int DECAY_W   = 16;
	localparam int WCOUNT_W  = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 40;
	localparam int W_W       = 17;   // Q1.16 weight
	localparam int ZW        = 34;   // CORDIC angle accumulator
	localparam int CORDIC_STEPS = 20;
	localparam int STEP_W    = 5;

	localparam logic [WCOUNT_W-1:0] WCOUNT_RST  = 5'd10;
	localparam logic [STAMP_W-1:0]  MAX_AGE_RST = 40'd2000000;
	localparam logic [DECAY_W-1:0]  DECAY_RST   = 16'd58982;
	localparam logic [W_W-1:0]      W_ONE       = 17'h10000;

	localparam logic signed [POS_W-1:0] CORDIC_X0 = 32'sd652032874;
	localparam logic signed [ZW-1:0] Z_HALF    = 34'sh080000000;
	localparam logic signed [ZW-1:0] Z_QUARTER = 34'sh040000000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WCOUNT  = 2'd0,
		CFG_MAX_AGE = 2'd1,
		CFG_DECAY   = 2'd2
	} pwma_cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SC_GO,
		ST_SC_WAIT,
		ST_WRITE,
		ST_DROP_RD,
		ST_DROP_CHK,
		ST_ACC_RD,
		ST_ACC_MUL,
		ST_ACC_ADD,
		ST_PREP,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FIN
	} pwma_state_t;

	typedef struct packed {
		logic accept;
		logic sc_start;
		logic wr;
		logic drop_rd;
		logic drop;
		logic acc_init;
		logic acc_mul;
		logic acc_add;
		logic prep;
		logic div_start;
		logic out_load;
	} pwma_cmd_t;

	typedef struct packed {
		logic cordic_busy;
		logic div_busy;
		logic drop_need;
		logic acc_last;
	} pwma_sts_t;

	function automatic logic [31:0] pwma_atan(input logic [STEP_W-1:0] i);
		logic [31:0] a;
		case (i)
			5'd0:  a = 32'h20000000;
			5'd1:  a = 32'h12E4051E;
			5'd2:  a = 32'h09FB385B;
			5'd3:  a = 32'h051111D4;
			5'd4:  a = 32'h028B0D43;
			5'd5:  a = 32'h0145D7E1;
			5'd6:  a = 32'h00A2F61E;
			5'd7:  a = 32'h00517C55;
			5'd8:  a = 32'h0028BE53;
			5'd9:  a = 32'h00145F2F;
			5'd10: a = 32'h000A2F98;
			5'd11: a = 32'h000517CC;
			5'd12: a = 32'h00028BE6;
			5'd13: a = 32'h000145F3;
			5'd14: a = 32'h0000A2F9;
			5'd15: a = 32'h0000517C;
			5'd16: a = 32'h000028BE;
			5'd17: a = 32'h0000145F;
			5'd18: a = 32'h00000A2F;
			5'd19: a = 32'h00000517;
			default: a = 32'h0;
		endcase
		return a;
	endfunction

endpackage

>>> design/pwma_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in POS_W bits, so only the low POS_W numerator bits iterate.
module pwma_div import pwma_pkg::*; #(
	parameter int NUM_W = 53,
	parameter int DEN_W = 21
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [POS_W-1:0] quo
);

	localparam int CNT_W = $clog2(POS_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [POS_W-1:0] lo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, lo_q[POS_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(POS_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[NUM_W-1:POS_W];
			lo_q  <= num[POS_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			lo_q  <= {lo_q[POS_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = lo_q;

endmodule

>>> design/pwma_cordic.sv
`timescale 1ns / 1ps
// Iterative CORDIC, one micro-rotation per cycle. Rotation mode steers by
// the sign of z, vectoring mode by the sign of y.
module pwma_cordic import pwma_pkg::*; #(
	parameter int W = 55
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                vec,
	input  logic signed [W-1:0] x0,
	input  logic signed [W-1:0] y0,
	input  logic signed [ZW-1:0] z0,
	output logic                busy,
	output logic signed [W-1:0] x,
	output logic signed [W-1:0] y,
	output logic signed [ZW-1:0] z
);

	logic signed [W-1:0]  x_q, y_q, dx, dy;
	logic signed [ZW-1:0] z_q, ang;
	logic [STEP_W-1:0]    i_q;
	logic                 busy_q;
	logic                 vec_q;
	logic                 dir;

	assign dx  = y_q >>> i_q;
	assign dy  = x_q >>> i_q;
	assign ang = $signed(ZW'(pwma_atan(i_q)));
	assign dir = vec_q ? y_q[W-1] : !z_q[ZW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q    <= '0;
		end else if (busy_q) begin
			i_q <= i_q + 1'b1;
			if (i_q == STEP_W'(CORDIC_STEPS - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x0;
			y_q   <= y0;
			z_q   <= z0;
			vec_q <= vec;
		end else if (busy_q) begin
			if (dir) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ang;
			end
		end
	end

	assign busy = busy_q;
	assign x    = x_q;
	assign y    = y_q;
	assign z    = z_q;

endmodule

>>> design/pwma_dp.sv
`timescale 1ns / 1ps
module pwma_dp import pwma_pkg::*; #(
	parameter int WINDOW_MAX = PWMA_WINDOW_MAX_DFLT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_idx,
	input  logic [CFG_DATA_W-1:0]    cfg_wdata,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [POS_W-1:0]  pos_z,
	input  logic signed [YAW_W-1:0]  yaw_in,
	input  logic [STAMP_W-1:0]       stamp,
	input  pwma_cmd_t                cmd,
	output pwma_sts_t                sts,
	output logic signed [POS_W-1:0]  mean_x,
	output logic signed [POS_W-1:0]  mean_y,
	output logic signed [POS_W-1:0]  mean_z,
	output logic signed [YAW_W-1:0]  mean_yaw
);

	localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int FW    = $clog2(WINDOW_MAX + 1);
	localparam int SW    = ((AW > FW) ? AW : FW) + 1;
	localparam int LW    = (FW > WCOUNT_W) ? FW : WCOUNT_W;
	localparam int TW_W  = W_W + $clog2(WINDOW_MAX);
	localparam int ACC_W = POS_W + TW_W;
	localparam int PW    = POS_W + W_W + 1;
	localparam int CW    = ACC_W + 2;
	localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_MAX - 1);
	localparam logic [FW-1:0] FILL_MAX  = FW'(WINDOW_MAX);
	localparam logic [LW-1:0] LIM_MAX   = LW'(WINDOW_MAX);

	function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] a);
		return (a == LAST_SLOT) ? '0 : a + 1'b1;
	endfunction

	function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] a);
		return (a == '0) ? LAST_SLOT : a - 1'b1;
	endfunction

	function automatic logic [ACC_W-1:0] round_num(input logic signed [ACC_W-1:0] v,
			input logic [TW_W-1:0] t);
		logic [ACC_W-1:0] mag;
		mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
		return mag + ACC_W'(t >> 1);
	endfunction

	// configuration
	logic [WCOUNT_W-1:0] wcount_q;
	logic [STAMP_W-1:0]  max_age_q;
	logic [DECAY_W-1:0]  decay_q;
	logic [LW-1:0]       limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcount_q  <= WCOUNT_RST;
			max_age_q <= MAX_AGE_RST;
			decay_q   <= DECAY_RST;
		end else if (cfg_we) begin
			unique case (pwma_cfg_idx_t'(cfg_idx))
				CFG_WCOUNT:  wcount_q  <= cfg_wdata[WCOUNT_W-1:0];
				CFG_MAX_AGE: max_age_q <= cfg_wdata[STAMP_W-1:0];
				CFG_DECAY:   decay_q   <= cfg_wdata[DECAY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (wcount_q == '0)
			limit = LW'(1);
		else if (LW'(wcount_q) > LIM_MAX)
			limit = LIM_MAX;
		else
			limit = LW'(wcount_q);
	end

	// input item
	logic signed [POS_W-1:0] px_q, py_q, pz_q;
	logic signed [YAW_W-1:0] yaw_q;
	logic [STAMP_W-1:0]      stamp_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			px_q    <= pos_x;
			py_q    <= pos_y;
			pz_q    <= pos_z;
			yaw_q   <= yaw_in;
			stamp_q <= stamp;
		end
	end

	// ring bookkeeping
	logic [AW-1:0] oldest_q, newest_q, ptr_q;
	logic [FW-1:0] fill_q, cnt_q;
	logic [SW-1:0] slot_sum;
	logic [AW-1:0] slot;

	assign slot_sum = SW'(oldest_q) + SW'(fill_q);
	assign slot = (slot_sum >= SW'(WINDOW_MAX)) ? AW'(slot_sum - SW'(WINDOW_MAX))
	                                            : AW'(slot_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			fill_q   <= '0;
		end else if (cmd.accept) begin
			// full ring: oldest goes before the new item lands
			if (fill_q == FILL_MAX) begin
				oldest_q <= slot_inc(oldest_q);
				fill_q   <= FILL_MAX - 1'b1;
			end
		end else if (cmd.wr) begin
			fill_q <= fill_q + 1'b1;
		end else if (cmd.drop) begin
			oldest_q <= slot_inc(oldest_q);
			fill_q   <= fill_q - 1'b1;
		end
	end

	// CORDIC shared by sin/cos of the new yaw and the final atan2
	logic signed [ZW-1:0] z_rot;
	logic                 flip_rot, flip_q;
	logic signed [CW-1:0] vx0_q, vy0_q, cx, cy, c0x, c0y;
	logic signed [ZW-1:0] vz0_q, cz, c0z;
	logic                 cordic_busy;

	always_comb begin
		z_rot    = {{(ZW - YAW_W - 16){yaw_q[YAW_W-1]}}, yaw_q, 16'h0};
		flip_rot = 1'b0;
		if (z_rot > Z_QUARTER) begin
			z_rot    = z_rot - Z_HALF;
			flip_rot = 1'b1;
		end else if (z_rot < -Z_QUARTER) begin
			z_rot    = z_rot + Z_HALF;
			flip_rot = 1'b1;
		end
	end

	assign c0x = cmd.sc_start ? CW'(CORDIC_X0) : vx0_q;
	assign c0y = cmd.sc_start ? '0 : vy0_q;
	assign c0z = cmd.sc_start ? z_rot : vz0_q;

	always_ff @(posedge clk) begin
		if (cmd.sc_start)
			flip_q <= flip_rot;
	end

	pwma_cordic #(.W(CW)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sc_start | cmd.div_start),
		.vec    (cmd.div_start),
		.x0     (c0x),
		.y0     (c0y),
		.z0     (c0z),
		.busy   (cordic_busy),
		.x      (cx),
		.y      (cy),
		.z      (cz)
	);

	// window memories; cos/sin are kept per entry so the walk needs no CORDIC
	logic signed [POS_W-1:0] mem_x [WINDOW_MAX];
	logic signed [POS_W-1:0] mem_y [WINDOW_MAX];
	logic signed [POS_W-1:0] mem_z [WINDOW_MAX];
	logic signed [POS_W-1:0] mem_c [WINDOW_MAX];
	logic signed [POS_W-1:0] mem_s [WINDOW_MAX];
	logic [STAMP_W-1:0]      mem_t [WINDOW_MAX];
	logic signed [POS_W-1:0] rd_x_q, rd_y_q, rd_z_q, rd_c_q, rd_s_q;
	logic [STAMP_W-1:0]      rd_t_q;
	logic [AW-1:0]           rd_addr;
	logic signed [CW-1:0]    cos_v, sin_v;

	assign rd_addr = cmd.drop_rd ? oldest_q : ptr_q;
	assign cos_v   = flip_q ? -cx : cx;
	assign sin_v   = flip_q ? -cy : cy;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem_x[slot] <= px_q;
			mem_y[slot] <= py_q;
			mem_z[slot] <= pz_q;
			mem_c[slot] <= cos_v[POS_W-1:0];
			mem_s[slot] <= sin_v[POS_W-1:0];
			mem_t[slot] <= stamp_q;
		end
		rd_x_q <= mem_x[rd_addr];
		rd_y_q <= mem_y[rd_addr];
		rd_z_q <= mem_z[rd_addr];
		rd_c_q <= mem_c[rd_addr];
		rd_s_q <= mem_s[rd_addr];
		rd_t_q <= mem_t[rd_addr];
	end

	// age check on the oldest entry; a stamp going backwards counts as age zero
	logic [STAMP_W-1:0] age;
	assign age = (stamp_q >= rd_t_q) ? stamp_q - rd_t_q : '0;

	// weighted walk from newest to oldest
	logic [W_W-1:0]          w_q, wn_q;
	logic [W_W+DECAY_W-1:0]  w_mul;
	logic signed [PW-1:0]    prod_x_q, prod_y_q, prod_z_q, prod_c_q, prod_s_q;
	logic signed [ACC_W-1:0] sum_x_q, sum_y_q, sum_z_q, sum_c_q, sum_s_q;
	logic [TW_W-1:0]         tw_q;
	logic signed [W_W:0]     w_sg;

	assign w_mul = w_q * decay_q;
	assign w_sg  = $signed({1'b0, w_q});

	always_ff @(posedge clk) begin
		if (cmd.wr)
			newest_q <= slot;
		if (cmd.acc_init) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			sum_c_q <= '0;
			sum_s_q <= '0;
			tw_q    <= '0;
			w_q     <= W_ONE;
			cnt_q   <= fill_q;
			ptr_q   <= newest_q;
		end
		if (cmd.acc_mul) begin
			prod_x_q <= rd_x_q * w_sg;
			prod_y_q <= rd_y_q * w_sg;
			prod_z_q <= rd_z_q * w_sg;
			prod_c_q <= rd_c_q * w_sg;
			prod_s_q <= rd_s_q * w_sg;
			wn_q     <= w_mul[W_W+DECAY_W-1:DECAY_W];
		end
		if (cmd.acc_add) begin
			sum_x_q <= sum_x_q + ACC_W'(prod_x_q);
			sum_y_q <= sum_y_q + ACC_W'(prod_y_q);
			sum_z_q <= sum_z_q + ACC_W'(prod_z_q);
			sum_c_q <= sum_c_q + ACC_W'(prod_c_q);
			sum_s_q <= sum_s_q + ACC_W'(prod_s_q);
			tw_q    <= tw_q + TW_W'(w_q);
			w_q     <= wn_q;
			ptr_q   <= slot_dec(ptr_q);
			cnt_q   <= cnt_q - 1'b1;
		end
	end

	// rounding prep, then three dividers alongside the atan2 run
	logic [ACC_W-1:0] num_x_q, num_y_q, num_z_q;
	logic             neg_x_q, neg_y_q, neg_z_q, yz_q;
	logic [POS_W-1:0] q_x, q_y, q_z;
	logic             bx, by, bz;

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			num_x_q <= round_num(sum_x_q, tw_q);
			num_y_q <= round_num(sum_y_q, tw_q);
			num_z_q <= round_num(sum_z_q, tw_q);
			neg_x_q <= sum_x_q[ACC_W-1];
			neg_y_q <= sum_y_q[ACC_W-1];
			neg_z_q <= sum_z_q[ACC_W-1];
			yz_q    <= (sum_c_q == '0) && (sum_s_q == '0);
			// left half-plane: turn the vector by pi first
			if (sum_c_q[ACC_W-1]) begin
				vx0_q <= -CW'(sum_c_q);
				vy0_q <= -CW'(sum_s_q);
				vz0_q <= Z_HALF;
			end else begin
				vx0_q <= CW'(sum_c_q);
				vy0_q <= CW'(sum_s_q);
				vz0_q <= '0;
			end
		end
	end

	pwma_div #(.NUM_W(ACC_W), .DEN_W(TW_W)) u_div_x (
		.clk (clk), .arst_n (arst_n), .start (cmd.div_start),
		.num (num_x_q), .den (tw_q), .busy (bx), .quo (q_x)
	);

	pwma_div #(.NUM_W(ACC_W), .DEN_W(TW_W)) u_div_y (
		.clk (clk), .arst_n (arst_n), .start (cmd.div_start),
		.num (num_y_q), .den (tw_q), .busy (by), .quo (q_y)
	);

	pwma_div #(.NUM_W(ACC_W), .DEN_W(TW_W)) u_div_z (
		.clk (clk), .arst_n (arst_n), .start (cmd.div_start),
		.num (num_z_q), .den (tw_q), .busy (bz), .quo (q_z)
	);

	// output register
	logic [31:0]             yaw_rnd;
	logic signed [POS_W-1:0] mean_x_q, mean_y_q, mean_z_q;
	logic signed [YAW_W-1:0] mean_yaw_q;

	assign yaw_rnd = cz[31:0] + 32'h0000_8000;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mean_x_q   <= neg_x_q ? -$signed(q_x) : $signed(q_x);
			mean_y_q   <= neg_y_q ? -$signed(q_y) : $signed(q_y);
			mean_z_q   <= neg_z_q ? -$signed(q_z) : $signed(q_z);
			mean_yaw_q <= yz_q ? '0 : $signed(yaw_rnd[31:16]);
		end
	end

	assign mean_x   = mean_x_q;
	assign mean_y   = mean_y_q;
	assign mean_z   = mean_z_q;
	assign mean_yaw = mean_yaw_q;

	assign sts.cordic_busy = cordic_busy;
	assign sts.div_busy    = bx | by | bz;
	assign sts.drop_need   = (LW'(fill_q) > limit) || (age > max_age_q);
	assign sts.acc_last    = (cnt_q == FW'(1));

endmodule

>>> design/pwma_ctrl.sv
`timescale 1ns / 1ps
module pwma_ctrl import pwma_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_stall,
	input  pwma_sts_t sts,
	output logic      in_stall,
	output logic      out_valid,
	output pwma_cmd_t cmd
);

	pwma_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_SC_GO;
			ST_SC_GO:    state_d = ST_SC_WAIT;
			ST_SC_WAIT:  if (!sts.cordic_busy) state_d = ST_WRITE;
			ST_WRITE:    state_d = ST_DROP_RD;
			ST_DROP_RD:  state_d = ST_DROP_CHK;
			ST_DROP_CHK: state_d = sts.drop_need ? ST_DROP_RD : ST_ACC_RD;
			ST_ACC_RD:   state_d = ST_ACC_MUL;
			ST_ACC_MUL:  state_d = ST_ACC_ADD;
			ST_ACC_ADD:  state_d = sts.acc_last ? ST_PREP : ST_ACC_RD;
			ST_PREP:     state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: if (!sts.div_busy && !sts.cordic_busy) state_d = ST_FIN;
			ST_FIN:      if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:     cmd.accept = in_valid;
			ST_SC_GO:    cmd.sc_start = 1'b1;
			ST_WRITE:    cmd.wr = 1'b1;
			ST_DROP_RD:  cmd.drop_rd = 1'b1;
			ST_DROP_CHK: begin
				cmd.drop     = sts.drop_need;
				cmd.acc_init = !sts.drop_need;
			end
			ST_ACC_MUL:  cmd.acc_mul = 1'b1;
			ST_ACC_ADD:  cmd.acc_add = 1'b1;
			ST_PREP:     cmd.prep = 1'b1;
			ST_DIV_GO:   cmd.div_start = 1'b1;
			ST_FIN:      cmd.out_load = out_free;
			default:     ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> design/pose_weighted_moving_average_core.sv
`timescale 1ns / 1ps
// Exponentially weighted moving average of pose samples with circular yaw mean.
// Input channel: in_valid / in_stall carries one sample (pos_x/y/z Q16.16,
// yaw_in binary angle, stamp in us). Output channel: out_valid / out_stall
// carries mean_x/y/z and mean_yaw, one result item per input item.
// Config: cfg_we writes cfg_wdata to register cfg_idx (0 window_count,
// 1 max_age, 2 decay) on the clock edge; write only while the block is idle.
// One item at a time: in_stall is high from acceptance until the result is
// loaded into the output register. Per item, the block runs the sin/cos CORDIC
// of the new yaw, drops aged or surplus entries one at a time, walks the
// window with a read, a multiply and an add for each entry (one memory read
// port, one multiply stage), and then runs the 32-step dividers alongside the
// atan2 CORDIC.
// A finished result sits in the output register; the next item is accepted
// while it waits. If the receiver still stalls when the following result is
// ready, the block holds that result internally and keeps in_stall high.
// Reset (arst_n low) empties the window and restores the default registers.
module pose_weighted_moving_average_core import pwma_pkg::*; #(
	parameter int WINDOW_MAX = PWMA_WINDOW_MAX_DFLT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_idx,
	input  logic [CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [POS_W-1:0]  pos_z,
	input  logic signed [YAW_W-1:0]  yaw_in,
	input  logic [STAMP_W-1:0]       stamp,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [POS_W-1:0]  mean_x,
	output logic signed [POS_W-1:0]  mean_y,
	output logic signed [POS_W-1:0]  mean_z,
	output logic signed [YAW_W-1:0]  mean_yaw
);

	pwma_cmd_t cmd;
	pwma_sts_t sts;

	pwma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	pwma_dp #(.WINDOW_MAX(WINDOW_MAX)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.yaw_in    (yaw_in),
		.stamp     (stamp),
		.cmd       (cmd),
		.sts       (sts),
		.mean_x    (mean_x),
		.mean_y    (mean_y),
		.mean_z    (mean_z),
		.mean_yaw  (mean_yaw)
	);

endmodule

>>> design/pwma_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pwma_chk import pwma_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [POS_W-1:0] mean_x,
	input logic signed [YAW_W-1:0] mean_yaw
);

	// a held result stays put
	`PWMA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(mean_x) && $stable(mean_yaw))

	// once an item is taken the block is busy with it
	`PWMA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// no result can appear the cycle right after an item is taken
	`PWMA_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall, !$rose(out_valid))

	// the block frees its input only when it has just delivered a result
	`PWMA_ASSERT_NOW(a_free_with_result, $fell(in_stall), out_valid)

endmodule

bind pose_weighted_moving_average_core pwma_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.mean_x    (mean_x),
	.mean_yaw  (mean_yaw)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import pwma_pkg::*;

	localparam int WMAX = 16;
	localparam int STEPS = 20;
	localparam int EXP_DEPTH = 64;
	localparam logic [31:0] ATAN_TAB [STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517};

	typedef struct packed {
		logic signed [31:0] mx;
		logic signed [31:0] my;
		logic signed [31:0] mz;
		logic signed [15:0] myaw;
	} pose_mean_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [15:0] yaw_in = '0;
	logic [39:0] stamp = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] mean_x, mean_y, mean_z;
	logic signed [15:0] mean_yaw;

	always #10 clk = ~clk;

	pose_weighted_moving_average_core u_top (.*);

	// predictor state
	int unsigned win_count = 10;
	longint unsigned age_limit = 2000000;
	int unsigned decay_q16 = 58982;
	logic signed [31:0] ring_x [WMAX], ring_y [WMAX], ring_z [WMAX];
	logic signed [15:0] ring_yaw [WMAX];
	logic [39:0] ring_t [WMAX];
	int unsigned head = 0, fill = 0;

	// expected results, circular buffer
	pose_mean_t exp_buf [EXP_DEPTH];
	int exp_wr = 0, exp_rd = 0;
	int errors = 0, n_items = 0, n_results = 0;
	logic [39:0] t_now = 0;
	bit stall_hold = 0;
	bit rx_quiet = 0;

	function automatic longint fshr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic void yaw_to_cs(logic signed [15:0] a, output longint c, output longint s);
		longint z, x, y, dx, dy;
		bit flip;
		z = longint'(a) * 65536;
		x = 652032874;
		y = 0;
		flip = 0;
		if (z > 64'sd1073741824) begin
			z -= 64'sd2147483648; flip = 1;
		end else if (z < -64'sd1073741824) begin
			z += 64'sd2147483648; flip = 1;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = fshr(y, i);
			dy = fshr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic logic [15:0] cs_to_yaw(longint s, longint c);
		longint x, y, dx, dy;
		logic [31:0] z;
		if (s == 0 && c == 0) return 16'h0;
		x = c; y = s; z = 0;
		if (c < 0) begin
			x = -c; y = -s; z = 32'h80000000;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = fshr(y, i);
			dy = fshr(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; z += ATAN_TAB[i];
			end else begin
				x -= dx; y += dy; z -= ATAN_TAB[i];
			end
		end
		z = z + 32'h8000;
		return z[31:16];
	endfunction

	function automatic logic [31:0] div_round(longint num, longint den);
		longint unsigned mag, q;
		mag = num < 0 ? longint'(-num) : num;
		q = (mag + den / 2) / den;
		return num < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic pose_mean_t window_mean(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz, logic signed [15:0] pyaw, logic [39:0] ts);
		int unsigned lim, slot, idx;
		longint unsigned w, age;
		longint sx, sy, sz, ss, sc, tw, c, s;
		pose_mean_t r;
		lim = win_count < 1 ? 1 : (win_count > WMAX ? WMAX : win_count);
		if (fill >= WMAX) begin
			head = (head + 1) % WMAX;
			fill = WMAX - 1;
		end
		slot = (head + fill) % WMAX;
		ring_x[slot] = px; ring_y[slot] = py; ring_z[slot] = pz;
		ring_yaw[slot] = pyaw; ring_t[slot] = ts;
		fill++;
		while (fill > 0) begin
			age = ts >= ring_t[head] ? ts - ring_t[head] : 0;
			if (!(fill > lim || age > age_limit)) break;
			head = (head + 1) % WMAX;
			fill--;
		end
		w = 65536;
		sx = 0; sy = 0; sz = 0; ss = 0; sc = 0; tw = 0;
		for (int k = 0; k < fill; k++) begin
			idx = (head + fill - 1 - k) % WMAX;
			sx += longint'(ring_x[idx]) * longint'(w);
			sy += longint'(ring_y[idx]) * longint'(w);
			sz += longint'(ring_z[idx]) * longint'(w);
			yaw_to_cs(ring_yaw[idx], c, s);
			sc += c * longint'(w);
			ss += s * longint'(w);
			tw += w;
			w = (w * decay_q16) >> 16;
		end
		r.mx = div_round(sx, tw);
		r.my = div_round(sy, tw);
		r.mz = div_round(sz, tw);
		r.myaw = cs_to_yaw(ss, sc);
		return r;
	endfunction

	task automatic idle_gap(int pct_long);
		int n;
		n = ($urandom_range(99) < pct_long) ? $urandom_range(60, 10) : $urandom_range(3);
		if ($urandom_range(3) == 0) n = 0;
		if (n != 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// valid stays up after the accept; the next item or a gap replaces it
	task automatic send_pose(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz, logic signed [15:0] pyaw, logic [39:0] ts);
		in_valid <= 1'b1;
		pos_x <= px; pos_y <= py; pos_z <= pz; yaw_in <= pyaw; stamp <= ts;
		do @(posedge clk); while (in_stall);
		exp_buf[exp_wr % EXP_DEPTH] = window_mean(px, py, pz, pyaw, ts);
		exp_wr++;
		n_items++;
	endtask

	task automatic write_reg(pwma_cfg_idx_t r, logic [39:0] v);
		cfg_we <= 1'b1; cfg_idx <= r; cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (r)
			CFG_WCOUNT:  win_count = v[4:0];
			CFG_MAX_AGE: age_limit = v;
			CFG_DECAY:   decay_q16 = v[15:0];
			default: ;
		endcase
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_pos();
		case ($urandom_range(5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return $urandom_range(20000) - 10000;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random(int n, int gap_pct, int stamp_step_max);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(19) == 0 && t_now > 1000) t_now -= $urandom_range(1000);
			else t_now += $urandom_range(stamp_step_max);
			send_pose(rand_pos(), rand_pos(), rand_pos(), 16'($urandom), t_now);
			if (gap_pct > 0) idle_gap(gap_pct);
		end
	endtask

	task automatic test_directed;
		send_pose(32'sh7FFFFFFF, 32'sh80000000, 0, 16'sh7FFF, 0);
		send_pose(32'sh80000000, 32'sh7FFFFFFF, -1, 16'sh8000, 10);
		send_pose(1, -1, 32'sh7FFFFFFF, 16'sh4000, 20);
		send_pose(0, 0, 0, 16'shC000, 20);
		send_pose(100, 200, 300, 16'sh4001, 5);   // stamp goes backwards
		send_pose(-5, 5, 7, 16'shBFFF, 40'hFFFFFFFFFF);  // all older samples age out
		send_pose(3, 3, 3, 16'sh0000, 40'hFFFFFFFFFF);
		send_pose(3, 3, 3, 16'sh8000, 40'hFFFFFFFFFF); // opposite yaws
		for (int i = 0; i < 12; i++)
			send_pose(i * 65536, -i, i, 16'(i * 4096), 40'hFFFFFFFFFF);
		t_now = 0;
		drain();
	endtask

	task automatic test_config_sweep;
		int unsigned counts [6] = '{0, 1, 16, 31, 5, 17};
		logic [15:0] decays [6] = '{16'h0000, 16'hFFFF, 16'h8000, 16'd58982, 16'h0001, 16'hC000};
		logic [39:0] ages [6] = '{40'd0, 40'hFFFFFFFFFF, 40'd500, 40'd2000000, 40'd50, 40'd5000};
		for (int p = 0; p < 6; p++) begin
			write_reg(CFG_WCOUNT, 40'(counts[p]));
			write_reg(CFG_MAX_AGE, ages[p]);
			write_reg(CFG_DECAY, 40'(decays[p]));
			send_random(120, 20, 200);
			drain();
		end
	endtask

	task automatic test_backpressure;
		write_reg(CFG_WCOUNT, 40'd16);
		write_reg(CFG_MAX_AGE, 40'hFFFFFFFFFF);
		stall_hold = 1;
		send_random(5, 0, 100);
		stall_hold = 0;
		send_random(100, 0, 100);
		drain();
	endtask

	task automatic test_random;
		rx_quiet = 1;
		write_reg(CFG_WCOUNT, 40'($urandom_range(16, 1)));
		write_reg(CFG_MAX_AGE, 40'($urandom_range(3000, 100)));
		write_reg(CFG_DECAY, 40'($urandom));
		send_random(300, 10, 300);
		rx_quiet = 0;
		drain();
	endtask

	// receiver stall, with one long hold-off while the sender keeps pushing
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (stall_hold) begin
				out_stall <= 1'b1;
				repeat (600) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
				wait (!stall_hold);
			end else if (rx_quiet) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				n = ($urandom_range(19) == 0) ? $urandom_range(80, 10) : $urandom_range(2);
				if (n != 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
				repeat ($urandom_range(6, 1)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		pose_mean_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (exp_wr == exp_rd) begin
				errors++;
				if (errors <= 10) $display("ERROR: unexpected result at %0t", $time);
			end else begin
				e = exp_buf[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (e.mx !== mean_x || e.my !== mean_y || e.mz !== mean_z
						|| e.myaw !== mean_yaw) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: mean exp %0d %0d %0d yaw %0d got %0d %0d %0d yaw %0d",
							e.mx, e.my, e.mz, e.myaw, mean_x, mean_y, mean_z, mean_yaw);
				end
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_backpressure();
		test_random();
		repeat (200) @(posedge clk);
		errors += exp_wr - exp_rd;
		$display("Sent %0d pose items over window, age and decay sweeps; %0d means checked.",
			n_items, n_results);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#50ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
